// ===== src/cursor_sequence_table_defines.svh =====
// Assertion macros for the checks of cursor_sequence_table.
// Included by the checker module; holds nothing but macro definitions.
`ifndef CURSOR_SEQUENCE_TABLE_DEFINES_SVH
`define CURSOR_SEQUENCE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cursor_sequence_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cursor_sequence_table: next-cycle check failed");

`endif

// ===== src/cst_pkg.sv =====
// Shared types and constants of the cursor sequence table.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package cst_pkg;

   // Field widths of the request and response transfers.
   localparam int OP_W          = 4;
   localparam int ENTRY_VALUE_W = 32;
   localparam int STATUS_W      = 2;
   localparam int POSITION_W    = 5;
   localparam int VALUE_W       = 32;
   localparam int COUNT_W       = 6;
   localparam int REQ_TDATA_W   = 40;
   localparam int RSP_TDATA_W   = 48;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_READ           = 4'd0;
   localparam logic [OP_W-1:0] OP_START          = 4'd1;
   localparam logic [OP_W-1:0] OP_END            = 4'd2;
   localparam logic [OP_W-1:0] OP_ADVANCE        = 4'd3;
   localparam logic [OP_W-1:0] OP_INSERT         = 4'd4;
   localparam logic [OP_W-1:0] OP_INSERT_FRONT   = 4'd5;
   localparam logic [OP_W-1:0] OP_ATTACH         = 4'd6;
   localparam logic [OP_W-1:0] OP_ATTACH_BACK    = 4'd7;
   localparam logic [OP_W-1:0] OP_REMOVE_CURRENT = 4'd8;
   localparam logic [OP_W-1:0] OP_REMOVE_FRONT   = 4'd9;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOCURSOR = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request fields
      logic execute;   // apply the operation to the list
      logic load_rsp;  // fill the response register
   } ctrl_cmd_type;

endpackage

// ===== src/cursor_sequence_table.sv =====
// Top level of the cursor sequence table: joins the controller and the
// datapath to the request and response streams. Depends on cst_pkg.
`timescale 1ns / 1ps

// The block keeps an ordered list of up to CAPACITY_ENTRIES words and a
// cursor that points at one entry or at none. Each request transfer carries
// an operation code and a word; each produces exactly one response transfer
// that reports the status, the cursor, the word under the cursor and the
// entry count as they stand after the operation.
//
// A request is taken in the idle state, applied to the list in the execute
// state and has its response loaded into the output register in the load
// state, which waits while the response register is full and not drained.
// A new request is accepted once the three-step sequence returns to idle; an
// insert or removal shifts the entry cells within the single execute cycle.
//
// The response register separates the two sides: when the receiver stalls,
// the block still accepts and executes the next request and holds its result
// until the waiting response has been taken. Response data stays stable while
// rsp_tvalid is high and rsp_tready is low.
//
// Synchronous reset empties the list and clears the cursor. The stored words
// themselves are not cleared, since no entry is read before it is written.
module cursor_sequence_table #(
   parameter int CAPACITY_ENTRIES = 32,
   parameter int WORD_WIDTH       = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0 up: op[3:0], entry_value[35:4], zero fill[39:36].
   input  logic [cst_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0 up: status[1:0], cursor_valid[2], cursor_position[7:3],
   // current_value[39:8], entry_count[45:40], zero fill[47:46].
   output logic [cst_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import cst_pkg::*;

   ctrl_cmd_type          cmd;
   logic [OP_W-1:0]       req_op;
   logic [ENTRY_VALUE_W-1:0] req_entry_value;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_cursor_valid;
   logic [POSITION_W-1:0] rsp_cursor_position;
   logic [VALUE_W-1:0]    rsp_current_value;
   logic [COUNT_W-1:0]    rsp_entry_count;

   assign req_op          = req_tdata[OP_W-1:0];
   assign req_entry_value = req_tdata[OP_W+ENTRY_VALUE_W-1:OP_W];

   cst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   cst_datapath #(
      .CAPACITY_ENTRIES (CAPACITY_ENTRIES),
      .WORD_WIDTH       (WORD_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_op              (req_op),
      .req_entry_value     (req_entry_value),
      .rsp_status          (rsp_status),
      .rsp_cursor_valid    (rsp_cursor_valid),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_current_value   (rsp_current_value),
      .rsp_entry_count     (rsp_entry_count)
   );

   // Pack the response fields, lowest field first, with zero fill on top.
   assign rsp_tdata = {2'b00, rsp_entry_count, rsp_current_value,
                       rsp_cursor_position, rsp_cursor_valid, rsp_status};

endmodule

// ===== src/cst_ctrl.sv =====
// Controller of the cursor sequence table: sequences capture, execute and
// response load, and owns both handshakes. Depends on cst_pkg.
`timescale 1ns / 1ps

module cst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output cst_pkg::ctrl_cmd_type cmd
);
   import cst_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   // The response register can take a new result when empty or being drained.
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      req_tready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = S_LOAD;
         end
         S_LOAD: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== src/cst_datapath.sv =====
// Datapath of the cursor sequence table: the entry cells with their shift
// network, count and cursor registers, and the response register. Depends on cst_pkg.
`timescale 1ns / 1ps

module cst_datapath #(
   parameter int CAPACITY_ENTRIES = 32,
   parameter int WORD_WIDTH       = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cst_pkg::ctrl_cmd_type               cmd,
   input  logic [cst_pkg::OP_W-1:0]            req_op,
   input  logic [cst_pkg::ENTRY_VALUE_W-1:0]   req_entry_value,
   output logic [cst_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_cursor_valid,
   output logic [cst_pkg::POSITION_W-1:0]      rsp_cursor_position,
   output logic [cst_pkg::VALUE_W-1:0]         rsp_current_value,
   output logic [cst_pkg::COUNT_W-1:0]         rsp_entry_count
);
   import cst_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY_ENTRIES);
   localparam int CNT_W = $clog2(CAPACITY_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY_ENTRIES);

   logic [OP_W-1:0]       op_ff;
   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH+ENTRY_VALUE_W-1:0] word_ext;

   logic [WORD_WIDTH-1:0] entries_ff [CAPACITY_ENTRIES];
   logic [WORD_WIDTH-1:0] entries_in [CAPACITY_ENTRIES];

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                present_ff, present_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic             full, empty, do_place, do_remove;
   logic [CNT_W-1:0] idx_cnt, idx_next, count_dec, pos;

   logic [STATUS_W-1:0]   rsp_status_ff;
   logic                  rsp_valid_bit_ff;
   logic [POSITION_W-1:0] rsp_pos_ff;
   logic [VALUE_W-1:0]    rsp_value_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic [IDX_W+POSITION_W-1:0]   pos_ext;
   logic [WORD_WIDTH+VALUE_W-1:0] value_ext;
   logic [CNT_W+COUNT_W-1:0]      count_ext;

   // Incoming words are cut or zero-extended to the stored word width.
   assign word_ext = {{WORD_WIDTH{1'b0}}, req_entry_value};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         word_ff <= word_ext[WORD_WIDTH-1:0];
      end
   end

   // Operation decode: next count, cursor and status, plus the shift request.
   always_comb begin
      full       = count_ff >= CAP_CNT;
      empty      = count_ff == '0;
      idx_cnt    = CNT_W'(idx_ff);
      idx_next   = idx_cnt + 1'b1;
      count_dec  = count_ff - 1'b1;
      count_in   = count_ff;
      idx_in     = idx_ff;
      present_in = present_ff;
      status_in  = STATUS_DONE;
      do_place   = 1'b0;
      do_remove  = 1'b0;
      pos        = '0;
      case (op_ff)
         OP_START, OP_END: begin
            if (empty) begin
               status_in = STATUS_NOCURSOR;
            end else begin
               idx_in     = (op_ff == OP_START) ? '0 : count_dec[IDX_W-1:0];
               present_in = 1'b1;
            end
         end
         OP_ADVANCE: begin
            if (!present_ff) begin
               status_in = STATUS_NOCURSOR;
            end else if (idx_next >= count_ff) begin
               present_in = 1'b0;
            end else begin
               idx_in = idx_next[IDX_W-1:0];
            end
         end
         OP_INSERT, OP_INSERT_FRONT, OP_ATTACH, OP_ATTACH_BACK: begin
            case (op_ff)
               OP_INSERT:  pos = present_ff ? idx_cnt : '0;
               OP_ATTACH:  pos = present_ff ? idx_next : count_ff;
               OP_ATTACH_BACK: pos = count_ff;
               default:    pos = '0;
            endcase
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               // Not full, so the gap position stays below the capacity.
               do_place   = 1'b1;
               idx_in     = pos[IDX_W-1:0];
               present_in = 1'b1;
               count_in   = count_ff + 1'b1;
            end
         end
         OP_REMOVE_CURRENT: begin
            pos = idx_cnt;
            if (!present_ff) begin
               status_in = STATUS_NOCURSOR;
            end else begin
               do_remove = 1'b1;
               count_in  = count_dec;
               if (idx_cnt >= count_dec) begin
                  present_in = 1'b0;
                  idx_in     = '0;
               end
            end
         end
         OP_REMOVE_FRONT: begin
            if (!present_ff || empty) begin
               status_in = STATUS_NOCURSOR;
            end else begin
               do_remove  = 1'b1;
               count_in   = count_dec;
               idx_in     = '0;
               present_in = count_dec != '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Each cell keeps its word or takes the new word, its lower or upper neighbor's.
   always_comb begin
      for (int i = 0; i < CAPACITY_ENTRIES; i++) begin
         entries_in[i] = entries_ff[i];
         if (do_place) begin
            if (CNT_W'(i) == pos) begin
               entries_in[i] = word_ff;
            end else if (CNT_W'(i) > pos) begin
               entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (do_remove) begin
            if (CNT_W'(i) >= pos && i < CAPACITY_ENTRIES - 1) begin
               entries_in[i] = entries_ff[(i < CAPACITY_ENTRIES - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         entries_ff <= entries_in;
         status_ff  <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         idx_ff     <= '0;
         present_ff <= 1'b0;
      end else if (cmd.execute) begin
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         present_ff <= present_in;
      end
   end

   // Response fields, masked or zero-extended to the transfer field widths.
   assign pos_ext   = {{POSITION_W{1'b0}}, idx_ff};
   assign value_ext = {{VALUE_W{1'b0}}, entries_ff[idx_ff]};
   assign count_ext = {{COUNT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff    <= status_ff;
         rsp_valid_bit_ff <= present_ff;
         rsp_pos_ff       <= present_ff ? pos_ext[POSITION_W-1:0] : '0;
         rsp_value_ff     <= present_ff ? value_ext[VALUE_W-1:0] : '0;
         rsp_count_ff     <= count_ext[COUNT_W-1:0];
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_cursor_valid    = rsp_valid_bit_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_current_value   = rsp_value_ff;
   assign rsp_entry_count     = rsp_count_ff;

endmodule

// ===== src/cst_checker.sv =====
// Port-level checks for cursor_sequence_table, bound to the top level.
// Depends on cursor_sequence_table_defines.svh and cst_pkg.
`timescale 1ns / 1ps
`include "cursor_sequence_table_defines.svh"

module cst_checker #(
   parameter int CAPACITY_ENTRIES = 32
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cst_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import cst_pkg::*;

   // Position and count are only compared where they are not masked.
   localparam bit                 FIELDS_FIT = CAPACITY_ENTRIES <= 32;
   localparam logic [COUNT_W-1:0] CAP_COUNT  = COUNT_W'(CAPACITY_ENTRIES);

   logic                  req_xfer, rsp_stall;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_cursor_valid;
   logic [POSITION_W-1:0] rsp_position;
   logic [VALUE_W-1:0]    rsp_value;
   logic [COUNT_W-1:0]    rsp_count;
   logic                  no_cursor_fields_zero, status_count_ok, cursor_inside_ok;

   assign req_xfer         = req_tvalid && req_tready;
   assign rsp_stall        = rsp_tvalid && !rsp_tready;
   assign rsp_status       = rsp_tdata[1:0];
   assign rsp_cursor_valid = rsp_tdata[2];
   assign rsp_position     = rsp_tdata[7:3];
   assign rsp_value        = rsp_tdata[39:8];
   assign rsp_count        = rsp_tdata[45:40];

   assign no_cursor_fields_zero = (rsp_position == '0) && (rsp_value == '0);
   assign status_count_ok  = (rsp_status <= STATUS_NOCURSOR) &&
                             (!FIELDS_FIT || (rsp_count <= CAP_COUNT));
   assign cursor_inside_ok = !FIELDS_FIT || ({1'b0, rsp_position} < rsp_count);

   // A stalled response holds its data.
   `CST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // One request at a time: the block is busy in the cycle after a transfer.
   `CST_ASSERT_NEXT(a_req_busy, clock, reset, req_xfer, !req_tready)

   // Without a cursor the position and current word read as zero.
   `CST_ASSERT_NOW(a_no_cursor_zero, clock, reset, rsp_tvalid && !rsp_cursor_valid, no_cursor_fields_zero)

   // Status is one of the three codes and the count stays within capacity.
   `CST_ASSERT_NOW(a_status_count, clock, reset, rsp_tvalid, status_count_ok)

   // A valid cursor points inside the list.
   `CST_ASSERT_NOW(a_cursor_inside, clock, reset, rsp_tvalid && rsp_cursor_valid, cursor_inside_ok)

endmodule

bind cursor_sequence_table cst_checker #(
   .CAPACITY_ENTRIES (CAPACITY_ENTRIES)
) u_cst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
